@@ hdl/thruster_command_to_thrust_model_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the thruster thrust model
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef THRUSTER_COMMAND_TO_THRUST_MODEL_MACROS_SVH
`define THRUSTER_COMMAND_TO_THRUST_MODEL_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TCM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcm assertion failed");

// Next-cycle implication, disabled during reset
`define TCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcm assertion failed");

`endif

@@ hdl/tcm_pkg.sv @@
// ----------------------------------------------------------------------------
// tcm_pkg
// Types and constants shared by the thruster thrust model.
// ----------------------------------------------------------------------------
`default_nettype none

package tcm_pkg;

  typedef struct packed {
    logic [15:0]        trim;
    logic [15:0]        gain;
    logic [16:0]        rise;
    logic [16:0]        fall;
    logic signed [15:0] surface;
    logic [15:0]        band;
    logic [16:0]        ratio;
    logic [22:0]        limit;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_TRIM    = 3'd0,
    REG_GAIN    = 3'd1,
    REG_RISE    = 3'd2,
    REG_FALL    = 3'd3,
    REG_SURFACE = 3'd4,
    REG_BAND    = 3'd5,
    REG_RATIO   = 3'd6,
    REG_LIMIT   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_MERGE,
    ST_EMIT
  } state_t;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Pulse width breakpoints in 1/4096 us
  localparam logic signed [31:0] PW_MIN  = 32'sd4096000;
  localparam logic signed [31:0] PW_DBLO = 32'sd5877760;
  localparam logic signed [31:0] PW_MID  = 32'sd6144000;
  localparam logic signed [31:0] PW_DBHI = 32'sd6266880;
  localparam logic signed [31:0] PW_MAX  = 32'sd8192000;

  // Map coefficients, Q8.8
  localparam logic [10:0] FWD_A = 11'd1472;
  localparam logic [10:0] FWD_B = 11'd1004;
  localparam logic [7:0]  FWD_C = 8'd161;
  localparam logic [10:0] REV_A = 11'd648;
  localparam logic [10:0] REV_B = 11'd1088;
  localparam logic [7:0]  REV_C = 8'd79;

  // floor(y/125) = (y * DIV125_RECIP) >> 30 for y below 2^23
  localparam logic [23:0] DIV125_RECIP = 24'd8589935;
  // floor(y/3) = (y * DIV3_RECIP) >> 20 for y below 2^18
  localparam logic [18:0] DIV3_RECIP = 19'd349526;

endpackage

`default_nettype wire

@@ hdl/tcm_lane.sv @@
// ----------------------------------------------------------------------------
// tcm_lane
// Submergence of one sample point: linear ramp across the surface band,
// Q1.16, with a 16-step restoring divider for the ramp.
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_lane (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire signed [15:0]  height,
  input  tcm_pkg::cfg_t      cfg,
  output logic               busy,
  output logic [16:0]        sub
);
  import tcm_pkg::*;

  logic signed [17:0] z2, s2, lo, hi, span;
  logic [16:0]        divisor;
  logic [16:0]        rem;
  logic [15:0]        low_bits;
  logic [15:0]        quo;
  logic [3:0]         count;
  logic [17:0]        trial;
  logic               qbit;

  assign z2   = {{1{height[15]}}, height, 1'b0};
  assign s2   = {{1{cfg.surface[15]}}, cfg.surface, 1'b0};
  assign lo   = s2 - $signed({2'b00, cfg.band});
  assign hi   = s2 + $signed({2'b00, cfg.band});
  assign span = hi - z2;

  assign trial = {rem, low_bits[15]};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      count <= '0;
      busy  <= (cfg.band != 16'd0) && (z2 > lo) && (z2 < hi);
    end else if (busy) begin
      count <= count + 4'd1;
      if (count == 4'd15) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= span[16:0];
      divisor  <= {cfg.band, 1'b0};
      low_bits <= cfg.band;
      quo      <= '0;
      if (cfg.band == 16'd0) begin
        sub <= (height <= cfg.surface) ? ONE_Q16 : 17'd0;
      end else if (z2 <= lo) begin
        sub <= ONE_Q16;
      end else if (z2 >= hi) begin
        sub <= 17'd0;
      end
    end else if (busy) begin
      // one quotient bit a cycle
      rem      <= qbit ? 17'(trial - {1'b0, divisor}) : trial[16:0];
      low_bits <= {low_bits[14:0], 1'b0};
      quo      <= {quo[14:0], qbit};
      if (count == 4'd15) begin
        sub <= {1'b0, quo[14:0], qbit};
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/tcm_cmd.sv @@
// ----------------------------------------------------------------------------
// tcm_cmd
// Command path: trim and gain, seeded first-order lag, and the quadratic
// pulse-width-to-thrust map, sequenced over nine steps.
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_cmd (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire [15:0]         raw_command,
  input  tcm_pkg::cfg_t      cfg,
  output logic               busy,
  output logic signed [31:0] filter_value,
  output logic signed [15:0] thr
);
  import tcm_pkg::*;

  localparam logic [3:0] STEP_PROD  = 4'd0;
  localparam logic [3:0] STEP_REF   = 4'd1;
  localparam logic [3:0] STEP_DELTA = 4'd2;
  localparam logic [3:0] STEP_LAG   = 4'd3;
  localparam logic [3:0] STEP_COMMIT = 4'd4;
  localparam logic [3:0] STEP_DIV   = 4'd5;
  localparam logic [3:0] STEP_SQ    = 4'd6;
  localparam logic [3:0] STEP_POLY  = 4'd7;
  localparam logic [3:0] STEP_LAST  = 4'd8;

  logic [3:0]         step;
  logic               seeded;
  logic signed [16:0] diff;
  logic signed [32:0] prod;
  logic signed [31:0] ref_q;
  logic signed [32:0] delta;
  logic [16:0]        coef;
  logic signed [50:0] mprod;
  logic signed [50:0] mprod_rnd;
  logic signed [31:0] v_next;
  logic               fwd, rev, rev_q, none_q;
  logic signed [31:0] d_full;
  logic [23:0]        y;
  logic [47:0]        q;
  logic [16:0]        x;
  logic [33:0]        x2;
  logic [27:0]        bx;
  logic [44:0]        ax2;
  logic [47:0]        s;
  logic [10:0]        coef_a, coef_b;
  logic [7:0]         coef_c;
  logic signed [15:0] mag;

  assign mprod_rnd = mprod + 51'sd32768;
  assign v_next    = seeded ? filter_value + mprod_rnd[47:16] : ref_q;

  // Map region of the new filter value
  assign fwd    = (v_next >= PW_MIN) && (v_next <= PW_DBLO);
  assign rev    = (v_next >= PW_DBHI) && (v_next <= PW_MAX);
  assign d_full = fwd ? PW_MID - v_next : v_next - PW_MID;
  assign y      = {d_full[21:0], 2'b00} + 24'd62;

  assign x      = q[46:30];
  assign coef_a = rev_q ? REV_A : FWD_A;
  assign coef_b = rev_q ? REV_B : FWD_B;
  assign coef_c = rev_q ? REV_C : FWD_C;
  assign s      = {3'b000, ax2} + {4'b0000, bx, 16'h0000}
                - {8'h00, coef_c, 32'h0000_0000} + 48'h0000_8000_0000;
  assign mag    = s[47:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      step         <= '0;
      filter_value <= '0;
      seeded       <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 4'd1;
      if (step == STEP_COMMIT) begin
        filter_value <= v_next;
        seeded       <= 1'b1;
      end
      if (step == STEP_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff <= $signed({1'b0, raw_command}) - $signed({1'b0, cfg.trim});
    end else if (busy) begin
      unique case (step)
        STEP_PROD: prod <= 33'(diff) * 33'($signed({1'b0, cfg.gain}));
        STEP_REF: begin
          ref_q <= 32'((prod + 33'sd8) >>> 4);
        end
        STEP_DELTA: begin
          delta <= $signed({ref_q[31], ref_q}) - $signed({filter_value[31], filter_value});
          if (ref_q >= filter_value) begin
            coef <= (cfg.rise > ONE_Q16) ? ONE_Q16 : cfg.rise;
          end else begin
            coef <= (cfg.fall > ONE_Q16) ? ONE_Q16 : cfg.fall;
          end
        end
        STEP_LAG: mprod <= 51'(delta) * 51'($signed({1'b0, coef}));
        STEP_COMMIT: begin
          rev_q  <= rev;
          none_q <= !(fwd || rev);
          q      <= {24'h0, y};
        end
        STEP_DIV: q <= 48'(q[23:0]) * 48'(DIV125_RECIP);
        STEP_SQ: begin
          x2 <= 34'(x) * 34'(x);
          bx <= 28'(coef_b) * 28'(x);
        end
        STEP_POLY: ax2 <= 45'(coef_a) * 45'(x2);
        STEP_LAST: begin
          if (none_q) begin
            thr <= '0;
          end else begin
            thr <= rev_q ? -mag : mag;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/tcm_merge.sv @@
// ----------------------------------------------------------------------------
// tcm_merge
// Merge of the lane results: average submergence, density mix, thrust
// scaling and limit, and the filtered command readout.
// ----------------------------------------------------------------------------
`default_nettype none

module tcm_merge #(
  parameter int LANES = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  input  wire [16:0]         subs [LANES],
  input  wire [2:0]          n,
  input  wire signed [15:0]  thr_in,
  input  wire signed [31:0]  filt,
  input  tcm_pkg::cfg_t      cfg,
  output logic               busy,
  output logic signed [23:0] thrust,
  output logic [16:0]        avg,
  output logic signed [17:0] fc
);
  import tcm_pkg::*;

  localparam logic [2:0] STEP_DIV3  = 3'd0;
  localparam logic [2:0] STEP_AVG   = 3'd1;
  localparam logic [2:0] STEP_MIX   = 3'd2;
  localparam logic [2:0] STEP_MED   = 3'd3;
  localparam logic [2:0] STEP_SCALE = 3'd4;
  localparam logic [2:0] STEP_LAST  = 3'd5;

  logic [2:0]         step;
  logic [18:0]        sum_c, sum;
  logic [2:0]         n_q;
  logic [37:0]        prod3;
  logic [16:0]        r;
  logic [33:0]        am;
  logic [32:0]        scale;
  logic [49:0]        mp;
  logic [49:0]        mp_rnd;
  logic [16:0]        med;
  logic signed [33:0] tp;
  logic signed [33:0] tp_rnd;
  logic signed [24:0] t25, lim25;
  logic signed [32:0] fc_rnd;
  logic signed [24:0] fc25;

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < LANES; i++) begin
      if (i < int'(n)) begin
        sum_c = sum_c + {2'b00, subs[i]};
      end
    end
  end

  assign r      = (cfg.ratio > ONE_Q16) ? ONE_Q16 : cfg.ratio;
  // a full average with no air share gives exactly 2^32
  assign scale  = {r, 16'h0000} + am[32:0];
  assign mp_rnd = mp + 50'h0_0000_8000_0000;
  assign med    = (mp_rnd[49:32] > {1'b0, ONE_Q16}) ? ONE_Q16 : mp_rnd[48:32];
  assign tp_rnd = tp + 34'sd32768;
  assign t25    = {{7{tp_rnd[33]}}, tp_rnd[33:16]};
  assign lim25  = $signed({2'b00, cfg.limit});
  assign fc_rnd = $signed({filt[31], filt}) + 33'sd128;
  assign fc25   = fc_rnd[32:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == STEP_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum <= sum_c;
      n_q <= n;
    end else if (busy) begin
      unique case (step)
        STEP_DIV3: prod3 <= 38'(sum + 19'd1) * 38'(DIV3_RECIP);
        STEP_AVG: begin
          unique case (n_q)
            3'd2:    avg <= 17'((sum + 19'd1) >> 1);
            3'd3:    avg <= prod3[36:20];
            3'd4:    avg <= 17'((sum + 19'd2) >> 2);
            default: avg <= sum[16:0];
          endcase
        end
        STEP_MIX:   am <= 34'(avg) * 34'(ONE_Q16 - r);
        STEP_MED:   mp <= 50'(avg) * 50'(scale);
        STEP_SCALE: tp <= 34'(thr_in) * 34'($signed({1'b0, med}));
        STEP_LAST: begin
          if (t25 > lim25) begin
            thrust <= lim25[23:0];
          end else if (t25 < -lim25) begin
            thrust <= 24'(-lim25);
          end else begin
            thrust <= t25[23:0];
          end
          if (fc25 > 25'sd131071) begin
            fc <= 18'sd131071;
          end else if (fc25 < -25'sd131072) begin
            fc <= -18'sd131072;
          end else begin
            fc <= fc25[17:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/thruster_command_to_thrust_model.sv @@
// ----------------------------------------------------------------------------
// thruster_command_to_thrust_model
// Thruster command to thrust: lag-filtered PWM command, quadratic thrust map,
// submergence scaling and thrust limit, one request per control tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per tick: raw
//   command, command_present flag, sample count and up to four heights.
//   A request with command_present low is accepted while idle and dropped:
//   no result, no change to the filter.
//   Output channel (out_valid/out_ready) carries thrust, averaged
//   submergence and the filtered command; the result is held in an output
//   register until the receiver takes it.
//   From accept to out_valid a request runs through the 16 ramp divider
//   steps when any lane height lies inside the surface band, else through
//   the 9-step command path, then the merge start, the 6 merge steps, the
//   hand-off to the emit state and the output load.
//   One request is in flight at a time: no new request is taken until the
//   result is loaded; a stalled receiver holds the block in its load state.
//   Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once
//   and must only be made by the user while the block is idle; the block leaves this unchecked.
//   Reset clears the configuration to its defaults, empties the filter so
//   the next command seeds it, and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module thruster_command_to_thrust_model #(
  parameter int SAMPLE_POINTS = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire [2:0]          cfg_index,
  input  wire [22:0]         cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [15:0]         raw_command,
  input  wire                command_present,
  input  wire [2:0]          sample_count,
  input  wire signed [15:0]  height_a,
  input  wire signed [15:0]  height_b,
  input  wire signed [15:0]  height_c,
  input  wire signed [15:0]  height_d,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [23:0] thrust,
  output logic [16:0]        submerged_fraction,
  output logic signed [17:0] filtered_command
);
  import tcm_pkg::*;

  // Only the first four sample points have ports
  localparam int LANES = (SAMPLE_POINTS < 4) ? SAMPLE_POINTS : 4;

  cfg_t   cfg;
  state_t state, state_next;

  logic               accept_cmd;
  logic               merge_start;
  logic               load_out;
  logic [2:0]         n_clamp, n_q;
  logic signed [15:0] heights [4];
  logic [16:0]        subs [LANES];
  logic [LANES-1:0]   lane_busy;
  logic               cmd_busy, merge_busy;
  logic signed [31:0] filt;
  logic signed [15:0] thr_map;
  logic signed [23:0] m_thrust;
  logic [16:0]        m_avg;
  logic signed [17:0] m_fc;

  assign heights[0] = height_a;
  assign heights[1] = height_b;
  assign heights[2] = height_c;
  assign heights[3] = height_d;

  // Zero counts as one point; too many saturate to the lane count
  always_comb begin
    if (sample_count == 3'd0) begin
      n_clamp = 3'd1;
    end else if (sample_count > 3'(LANES)) begin
      n_clamp = 3'(LANES);
    end else begin
      n_clamp = sample_count;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trim    <= 16'd0;
      cfg.gain    <= 16'd4096;
      cfg.rise    <= 17'd1517;
      cfg.fall    <= 17'd1517;
      cfg.surface <= 16'sd0;
      cfg.band    <= 16'd100;
      cfg.ratio   <= 17'd80;
      cfg.limit   <= 23'd256000;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRIM:    cfg.trim    <= cfg_data[15:0];
        REG_GAIN:    cfg.gain    <= cfg_data[15:0];
        REG_RISE:    cfg.rise    <= cfg_data[16:0];
        REG_FALL:    cfg.fall    <= cfg_data[16:0];
        REG_SURFACE: cfg.surface <= cfg_data[15:0];
        REG_BAND:    cfg.band    <= cfg_data[15:0];
        REG_RATIO:   cfg.ratio   <= cfg_data[16:0];
        REG_LIMIT:   cfg.limit   <= cfg_data[22:0];
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && command_present) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!cmd_busy && (lane_busy == '0)) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (!merge_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready    = 1'b0;
    accept_cmd  = 1'b0;
    merge_start = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        accept_cmd = in_valid && command_present;
      end
      ST_CALC:  merge_start = !cmd_busy && (lane_busy == '0);
      ST_MERGE: ;
      ST_EMIT:  load_out = !out_valid || out_ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_cmd) begin
      n_q <= n_clamp;
    end
  end

  tcm_cmd u_cmd (
    .clk          (clk),
    .rst          (rst),
    .start        (accept_cmd),
    .raw_command  (raw_command),
    .cfg          (cfg),
    .busy         (cmd_busy),
    .filter_value (filt),
    .thr          (thr_map)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    tcm_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (accept_cmd),
      .height (heights[i]),
      .cfg    (cfg),
      .busy   (lane_busy[i]),
      .sub    (subs[i])
    );
  end

  tcm_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .start  (merge_start),
    .subs   (subs),
    .n      (n_q),
    .thr_in (thr_map),
    .filt   (filt),
    .cfg    (cfg),
    .busy   (merge_busy),
    .thrust (m_thrust),
    .avg    (m_avg),
    .fc     (m_fc)
  );

  // Output register: load when empty or being drained, hold under stall
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      thrust             <= m_thrust;
      submerged_fraction <= m_avg;
      filtered_command   <= m_fc;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tcm_checker.sv @@
// ----------------------------------------------------------------------------
// tcm_checker
// Port-level checks on the thruster thrust model, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thruster_command_to_thrust_model_macros.svh"

module tcm_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               command_present,
  input wire               out_valid,
  input wire               out_ready,
  input wire signed [23:0] thrust,
  input wire [16:0]        submerged_fraction
);

  // A stalled result holds
  `TCM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(thrust))

  // Averaged submergence never exceeds one
  `TCM_ASSERT_NOW(a_sub_range, clk, rst, out_valid, submerged_fraction <= 17'd65536)

  // A commanded request occupies the block
  `TCM_ASSERT_NEXT(a_busy_after, clk, rst, in_valid && in_ready && command_present, !in_ready)

  // A request without command is dropped and the block stays open
  `TCM_ASSERT_NEXT(a_drop, clk, rst, in_valid && in_ready && !command_present, in_ready)

  // A new result appears only while the input side is closed
  `TCM_ASSERT_NOW(a_new_result, clk, rst, $rose(out_valid), !$past(in_ready))

endmodule

bind thruster_command_to_thrust_model tcm_checker u_tcm_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .command_present    (command_present),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .thrust             (thrust),
  .submerged_fraction (submerged_fraction)
);

`default_nettype wire

@@ test/thruster_command_to_thrust_model_tb.sv @@
// ----------------------------------------------------------------------------
// thruster_command_to_thrust_model_tb
// Self-checking bench: drives control ticks through the request channel,
// predicts thrust, submergence and filtered command in step with the block,
// and compares every result in order. Random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module thruster_command_to_thrust_model_tb;
  import tcm_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct packed {
    logic signed [23:0] thrust;
    logic [16:0]        sub;
    logic signed [17:0] fcmd;
  } thrust_result_t;

  typedef struct packed {
    logic [15:0]        cmd;
    logic               present;
    logic [2:0]         count;
    logic signed [15:0] ha;
    logic signed [15:0] hb;
    logic signed [15:0] hc;
    logic signed [15:0] hd;
  } tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] raw_command = '0;
  logic command_present = 1'b0;
  logic [2:0] sample_count = 3'd1;
  logic signed [15:0] height_a = '0, height_b = '0, height_c = '0, height_d = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [23:0] thrust;
  logic [16:0] submerged_fraction;
  logic signed [17:0] filtered_command;

  thruster_command_to_thrust_model dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state: configuration and lag filter
  cfg_t            model_cfg;
  longint          lag_value;
  bit              lag_seeded;
  thrust_result_t  pending_thrust[$];

  int mismatches = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit quiet_mode = 0;     // no random idling on either side
  bit hold_receiver = 0;  // long receiver stall

  function automatic longint floor_div_pow2(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint round_pow2(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint clamp_q16(longint v);
    return (v > 65536) ? 65536 : v;
  endfunction

  function automatic longint pwm_to_thrust(longint p);
    longint d, x, a, b, c, s;
    bit rev;
    if (p > PW_DBLO && p < PW_DBHI) return 0;
    if (p >= PW_MIN && p <= PW_DBLO) begin
      d = PW_MID - p; a = FWD_A; b = FWD_B; c = -longint'(FWD_C); rev = 0;
    end else if (p >= PW_DBHI && p <= PW_MAX) begin
      d = p - PW_MID; a = REV_A; b = REV_B; c = -longint'(REV_C); rev = 1;
    end else begin
      return 0;
    end
    x = (d * 4 + 62) / 125;
    s = a * x * x + b * x * 65536 + c * 64'sd4294967296;
    s = round_pow2(s, 32);
    return rev ? -s : s;
  endfunction

  function automatic longint point_submergence(longint z);
    longint s, band, lo, hi, num;
    s = longint'(model_cfg.surface);
    band = longint'(model_cfg.band);
    if (band == 0) return (z <= s) ? 65536 : 0;
    lo = 2 * s - band;
    hi = 2 * s + band;
    if (2 * z <= lo) return 65536;
    if (2 * z >= hi) return 0;
    num = (hi - 2 * z) * 65536 + band;
    return num / (2 * band);
  endfunction

  // Advance the lag filter and queue the expected result for one tick
  function automatic void predict_thrust(tick_t t);
    longint refv, v, coef, thr, sum, avg, r, scale, med, fc;
    longint h[4];
    int n;
    thrust_result_t res;
    if (!t.present) return;
    refv = round_pow2((longint'(t.cmd) - longint'(model_cfg.trim)) *
                      longint'(model_cfg.gain), 4);
    if (!lag_seeded) begin
      v = refv;
      lag_seeded = 1;
    end else begin
      v = lag_value;
      coef = clamp_q16(refv >= v ? model_cfg.rise : model_cfg.fall);
      v = v + round_pow2((refv - v) * coef, 16);
    end
    lag_value = longint'(int'(v));
    v = lag_value;
    thr = pwm_to_thrust(v);
    n = t.count;
    if (n == 0) n = 1;
    if (n > 4) n = 4;
    h[0] = t.ha; h[1] = t.hb; h[2] = t.hc; h[3] = t.hd;
    sum = 0;
    for (int i = 0; i < n; i++) sum += point_submergence(h[i]);
    avg = (sum + n / 2) / n;
    if (avg > 65536) avg = 65536;
    r = clamp_q16(model_cfg.ratio);
    scale = r * 65536 + avg * (65536 - r);
    med = round_pow2(avg * scale, 32);
    if (med > 65536) med = 65536;
    if (med < 0) med = 0;
    thr = round_pow2(thr * med, 16);
    if (thr > longint'(model_cfg.limit)) thr = model_cfg.limit;
    if (thr < -longint'(model_cfg.limit)) thr = -longint'(model_cfg.limit);
    fc = round_pow2(v, 8);
    if (fc > 131071) fc = 131071;
    if (fc < -131072) fc = -131072;
    res.thrust = thr[23:0];
    res.sub = avg[16:0];
    res.fcmd = fc[17:0];
    pending_thrust = {pending_thrust, res};
  endfunction

  // Send one tick; valid is held until the block takes it
  task automatic send_tick(tick_t t);
    @(negedge clk);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 10) @(negedge clk);
    end
    in_valid <= 1'b1;
    {raw_command, command_present, sample_count,
     height_a, height_b, height_c, height_d} <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_thrust(t);
    ticks_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Write one register; block must be idle
  task automatic write_reg(cfg_reg_t idx, logic [22:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TRIM:    model_cfg.trim = val[15:0];
      REG_GAIN:    model_cfg.gain = val[15:0];
      REG_RISE:    model_cfg.rise = val[16:0];
      REG_FALL:    model_cfg.fall = val[16:0];
      REG_SURFACE: model_cfg.surface = val[15:0];
      REG_BAND:    model_cfg.band = val[15:0];
      REG_RATIO:   model_cfg.ratio = val[16:0];
      default:     model_cfg.limit = val[22:0];
    endcase
  endtask

  // Drain outstanding results, then allow for a dropped tick still in flight
  task automatic wait_idle();
    while (pending_thrust.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic tick_t random_tick();
    tick_t t;
    t.cmd = 16'($urandom);
    // Bias commands into the mapped 1000..2000 us window most of the time
    if ($urandom_range(3) != 0) t.cmd = 16'($urandom_range(16000, 32000));
    t.present = ($urandom_range(9) != 0);
    t.count = 3'($urandom);
    t.ha = 16'($urandom); t.hb = 16'($urandom);
    t.hc = 16'($urandom); t.hd = 16'($urandom);
    // Keep heights near the surface band for most ticks
    if ($urandom_range(3) != 0) begin
      t.ha = model_cfg.surface + $signed(16'($urandom_range(0, 400)) - 16'sd200);
      t.hb = model_cfg.surface + $signed(16'($urandom_range(0, 400)) - 16'sd200);
      t.hc = model_cfg.surface + $signed(16'($urandom_range(0, 400)) - 16'sd200);
      t.hd = model_cfg.surface + $signed(16'($urandom_range(0, 400)) - 16'sd200);
    end
    return t;
  endfunction

  // Result checker: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    thrust_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_thrust.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result thrust=%0d sub=%0d fcmd=%0d",
                   thrust, submerged_fraction, filtered_command);
      end else begin
        exp_res = pending_thrust.pop_front();
        if (thrust !== exp_res.thrust || submerged_fraction !== exp_res.sub ||
            filtered_command !== exp_res.fcmd) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp thrust=%0d sub=%0d fcmd=%0d, got %0d %0d %0d",
                     exp_res.thrust, exp_res.sub, exp_res.fcmd,
                     thrust, submerged_fraction, filtered_command);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_receiver) out_ready <= 1'b0;
    else if (quiet_mode) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 10);
  end

  // Watchdog: count cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("thruster_command_to_thrust_model_tb: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    tick_t t;
    logic [15:0] cmds[8] = '{16'd16000, 16'd32000, 16'd24000, 16'd0,
                             16'd65535, 16'd23000, 16'd24500, 16'd15999};
    // Ignored tick before any command must not seed the filter
    t = '{cmd: 16'd20000, present: 1'b0, count: 3'd1, default: '0};
    send_tick(t);
    foreach (cmds[i]) begin
      t.cmd = cmds[i]; t.present = 1'b1; t.count = 3'(i);
      t.ha = 16'sh7fff; t.hb = 16'sh8000; t.hc = 16'sd0; t.hd = 16'sd50;
      send_tick(t);
    end
    // Sample count extremes and heights at band edges
    for (int c = 0; c < 8; c++) begin
      t.cmd = 16'd18000; t.count = 3'(c);
      t.ha = -16'sd50; t.hb = 16'sd50; t.hc = 16'sd49; t.hd = -16'sd1;
      send_tick(t);
    end
    t.present = 1'b0; t.cmd = 16'hffff; t.count = 3'd7;
    t.ha = -16'sd1; t.hb = -16'sd1; t.hc = -16'sd1; t.hd = -16'sd1;
    send_tick(t);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // Fast filter, sharp surface step, full density, tiny limit
    write_reg(REG_RISE, 23'd65536);
    write_reg(REG_FALL, 23'd131071);
    write_reg(REG_BAND, 23'd0);
    write_reg(REG_RATIO, 23'd131071);
    write_reg(REG_LIMIT, 23'd100);
    for (int i = 0; i < 40; i++) send_tick(random_tick());
    wait_idle();
    // Large gain and trim; rise and fall at zero hold the filter at its value
    write_reg(REG_TRIM, 23'd65535);
    write_reg(REG_GAIN, 23'd65535);
    write_reg(REG_SURFACE, 23'h8000);
    write_reg(REG_BAND, 23'd65535);
    write_reg(REG_RATIO, 23'd0);
    write_reg(REG_LIMIT, 23'h7fffff);
    write_reg(REG_RISE, 23'd0);
    write_reg(REG_FALL, 23'd0);
    for (int i = 0; i < 40; i++) send_tick(random_tick());
    wait_idle();
    write_reg(REG_SURFACE, 23'h7fff);
    write_reg(REG_GAIN, 23'd0);
    for (int i = 0; i < 20; i++) send_tick(random_tick());
    wait_idle();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_TRIM, 23'($urandom_range(0, 2000)));
      write_reg(REG_GAIN, 23'($urandom_range(3500, 4700)));
      write_reg(REG_RISE, 23'($urandom_range(0, 70000)));
      write_reg(REG_FALL, 23'($urandom_range(0, 70000)));
      write_reg(REG_SURFACE, 23'($urandom_range(0, 65535)));
      write_reg(REG_BAND, 23'($urandom_range(0, 600)));
      write_reg(REG_RATIO, 23'($urandom_range(0, 70000)));
      write_reg(REG_LIMIT, 23'($urandom_range(0, 1) ? 256000 : $urandom_range(0, 8388607)));
      quiet_mode = (phase == 3);
      for (int i = 0; i < 200; i++) send_tick(random_tick());
      wait_idle();
    end
    quiet_mode = 0;
  endtask

  task automatic test_receiver_stall();
    // Hold off the receiver while the sender keeps offering ticks
    fork
      begin
        hold_receiver = 1;
        repeat (400) @(posedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 30; i++) send_tick(random_tick());
    join
    wait_idle();
  endtask

  initial begin
    model_cfg = '{trim: 16'd0, gain: 16'd4096, rise: 17'd1517, fall: 17'd1517,
                  surface: 16'sd0, band: 16'd100, ratio: 17'd80, limit: 23'd256000};
    lag_value = 0;
    lag_seeded = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_receiver_stall();
    test_register_extremes();
    test_random_settings();
    wait_idle();
    $display("covered %0d ticks and %0d results across directed, stall and random phases",
             ticks_sent, results_seen);
    if (mismatches == 0 && pending_thrust.size() == 0)
      $display("thruster_command_to_thrust_model_tb: done, clean");
    else
      $display("thruster_command_to_thrust_model_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
